// ----- rtl/core/probability_simplex_projection_unit_defines.svh -----
// Assertion macros for the projection unit
`ifndef PROBABILITY_SIMPLEX_PROJECTION_UNIT_DEFINES_SVH
`define PROBABILITY_SIMPLEX_PROJECTION_UNIT_DEFINES_SVH

`define PSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lbl failed");

`define PSP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lbl failed");

`endif

// ----- rtl/core/psp_pkg.sv -----
package psp_pkg;
  localparam int unsigned MaxElements = 64;
  localparam int unsigned IdxW = $clog2(MaxElements);
  localparam int unsigned CntW = $clog2(MaxElements + 1);
  localparam int unsigned SumW = 40;
  localparam int unsigned QuoW = SumW;
  localparam int unsigned TolW = 25;
  localparam logic [TolW-1:0] TolReset = 25'd168;
  localparam logic signed [SumW-1:0] QOne = 40'sd16777216;
  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  typedef struct packed {
    logic signed [31:0] in_value;
    logic               in_last;
  } psp_in_t;

  typedef struct packed {
    logic [24:0] out_value;
    logic        out_last;
  } psp_out_t;

  typedef struct packed {
    logic                   start;
    logic signed [SumW-1:0] dividend;
    logic [CntW-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [QuoW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SCAN, ST_SHDIV, ST_SHCHK, ST_MIN, ST_SUM, ST_EDIV,
    ST_ECHK, ST_EMIT, ST_WAIT
  } state_e;

  typedef enum logic [1:0] {MODE_ZERO, MODE_ONEHOT, MODE_SHIFT} mode_e;

  function automatic logic signed [SumW-1:0] sat_add(
      input logic signed [SumW-1:0] a, input logic signed [SumW-1:0] b);
    logic signed [SumW:0] s;
    s = {a[SumW-1], a} + {b[SumW-1], b};
    if (s[SumW] != s[SumW-1]) return s[SumW] ? SumMin : SumMax;
    return s[SumW-1:0];
  endfunction
endpackage

// ----- rtl/core/psp_divider.sv -----
module psp_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psp_pkg::div_req_t  req_i,
  output psp_pkg::div_rsp_t  rsp_o
);
  import psp_pkg::*;
  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0] rem_q, rem_d, quo_q, quo_d, mag;
  logic [CntW-1:0] den_q, den_d;
  logic            neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [SumW:0]   trial;

  assign mag = req_i.dividend[SumW-1] ? SumW'(-req_i.dividend) : req_i.dividend;
  assign trial = {rem_q, quo_q[SumW-1]} - {{(SumW+1-CntW){1'b0}}, den_q};

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; neg_d = neg_q;
    busy_d = busy_q; cnt_d = cnt_q; done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0; quo_d = mag; den_d = req_i.divisor;
      neg_d = req_i.dividend[SumW-1]; busy_d = 1'b1; cnt_d = StepW'(SumW);
    end else if (busy_q) begin
      if (!trial[SumW]) begin
        rem_d = trial[SumW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[SumW-2:0], quo_q[SumW-1]};
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

// ----- rtl/core/probability_simplex_projection_unit.sv -----
// Projection onto the probability simplex. Beats of a vector (up to 64
// signed Q8.24 elements, last marked or store full) are taken one a cycle;
// then the unit is busy: one scan for max and sum of |x|; unless the max
// dominates within the tolerance, a shared restoring divide plus a check
// for the uniform shift, and per elimination round a minimum scan, sum,
// divide and check; then K output beats, each through the EMIT and WAIT
// states. The single element store has one read port, so each pass reads
// the elements one by one.
module probability_simplex_projection_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [24:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  psp_pkg::psp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output psp_pkg::psp_out_t out_data_o
);
  import psp_pkg::*;

  logic signed [31:0] mem [MaxElements];
  logic signed [31:0] rd_q;
  logic [IdxW-1:0]    addr;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic [TolW-1:0] tol_q;
  logic [MaxElements-1:0] rm_q, rm_d;
  logic [CntW-1:0] k_q, k_d, m_q, m_d, i_q, i_d;
  logic            rv_q, rv_d;
  logic [IdxW-1:0] ri_q, ri_d;
  logic signed [SumW-1:0] rsum_q, rsum_d, acc_q, acc_d, shift_q, shift_d;
  logic signed [31:0] best_q, best_d;
  logic [IdxW-1:0] bidx_q, bidx_d;
  logic            bset_q, bset_d, ok_q, ok_d;
  logic            ovalid_q, ovalid_d;
  psp_out_t        odata_q, odata_d;
  div_req_t        dreq;
  div_rsp_t        drsp;
  logic            acc_in, mem_we, scan_end;
  logic signed [SumW-1:0] x, v, ax;

  assign acc_in = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_LOAD);
  assign mem_we = acc_in;
  assign x = SumW'(rd_q);
  assign ax = rd_q[31] ? -x : x;
  assign v = x + shift_q;
  assign scan_end = (i_q == k_q);

  always_comb begin
    addr = i_q[IdxW-1:0];
    if (state_q == ST_LOAD) addr = k_q[IdxW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[addr] <= in_data_i.in_value;
    rd_q <= mem[addr];
  end

  psp_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (acc_in && (in_data_i.in_last || k_q == CntW'(MaxElements-1)))
                  state_d = ST_SCAN;
      ST_SCAN:  if (scan_end && rv_q) state_d = ST_SHDIV;
      ST_SHDIV: if (mode_q == MODE_ONEHOT) state_d = ST_EMIT;
                else if (drsp.done) state_d = ST_SHCHK;
      ST_SHCHK: if (scan_end && rv_q) state_d = ST_MIN;
      ST_MIN:   if (ok_q) state_d = ST_EMIT;
                else if (scan_end && rv_q) state_d = ST_SUM;
      ST_SUM:   if (m_q == '0) state_d = ST_EMIT;
                else if (scan_end && rv_q) state_d = ST_EDIV;
      ST_EDIV:  if (drsp.done) state_d = ST_ECHK;
      ST_ECHK:  if (scan_end && rv_q) state_d = ST_MIN;
      ST_EMIT:  state_d = ST_WAIT;
      ST_WAIT:  if (!ovalid_q || out_ready_i) begin
                  if (scan_end && !ovalid_d) state_d = ST_LOAD;
                  else if (!scan_end) state_d = ST_EMIT;
                end
      default:  state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    k_d = k_q; m_d = m_q; i_d = i_q; rv_d = 1'b0; ri_d = i_q[IdxW-1:0];
    rsum_d = rsum_q; acc_d = acc_q; shift_d = shift_q; best_d = best_q;
    bidx_d = bidx_q; bset_d = bset_q; ok_d = ok_q; mode_d = mode_q;
    rm_d = rm_q; ovalid_d = ovalid_q; odata_d = odata_q;
    dreq = '{start: 1'b0, dividend: QOne - rsum_q, divisor: k_q};
    if (out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (acc_in) begin
          k_d = k_q + 1'b1;
          rsum_d = sat_add(rsum_q, SumW'(in_data_i.in_value));
          i_d = '0; acc_d = '0; bset_d = 1'b0; rm_d = '0;
        end
      end
      ST_SCAN: begin
        if (!scan_end) begin
          i_d = i_q + 1'b1; rv_d = 1'b1;
        end
        if (rv_q) begin
          acc_d = sat_add(acc_q, ax);
          if (!bset_q || rd_q > best_q) begin
            best_d = rd_q; bidx_d = ri_q; bset_d = 1'b1;
          end
        end
        if (scan_end && rv_q) begin
          if (best_d > 0 && (acc_d - SumW'(best_d)) < $signed({15'd0, tol_q})) begin
            mode_d = MODE_ONEHOT; i_d = '0;
          end else begin
            mode_d = MODE_SHIFT; dreq.start = 1'b1;
          end
        end
      end
      ST_SHDIV: begin
        if (drsp.done) begin
          shift_d = drsp.quotient; i_d = '0; ok_d = 1'b1;
        end
      end
      ST_SHCHK, ST_ECHK: begin
        if (!scan_end) begin
          i_d = i_q + 1'b1; rv_d = 1'b1;
        end
        if (rv_q && !rm_q[ri_q] && (v < 0 || v > QOne)) ok_d = 1'b0;
        if (scan_end && rv_q) begin
          i_d = '0; bset_d = 1'b0;
          if (state_q == ST_SHCHK) m_d = k_q;
        end
      end
      ST_MIN: begin
        if (ok_q) i_d = '0;
        else begin
          if (!scan_end) begin
            i_d = i_q + 1'b1; rv_d = 1'b1;
          end
          if (rv_q && !rm_q[ri_q] && (!bset_q || rd_q < best_q)) begin
            best_d = rd_q; bidx_d = ri_q; bset_d = 1'b1;
          end
          if (scan_end && rv_q) begin
            rm_d[bidx_d] = 1'b1; m_d = m_q - 1'b1; i_d = '0; acc_d = '0;
          end
        end
      end
      ST_SUM: begin
        if (m_q == '0) begin
          mode_d = MODE_ZERO; i_d = '0;
        end else begin
          if (!scan_end) begin
            i_d = i_q + 1'b1; rv_d = 1'b1;
          end
          if (rv_q && !rm_q[ri_q]) acc_d = sat_add(acc_q, x);
          if (scan_end && rv_q) begin
            dreq.start = 1'b1; dreq.dividend = QOne - acc_d; dreq.divisor = m_q;
          end
        end
      end
      ST_EDIV: begin
        if (drsp.done) begin
          shift_d = drsp.quotient; i_d = '0; ok_d = 1'b1;
        end
      end
      ST_EMIT: ;
      ST_WAIT: begin
        if ((!ovalid_q || out_ready_i) && !scan_end) begin
          ovalid_d = 1'b1;
          odata_d.out_last = (i_q + 1'b1 == k_q);
          unique case (mode_q)
            MODE_ONEHOT: odata_d.out_value = (ri_q == bidx_q) ? 25'(QOne) : '0;
            MODE_SHIFT:  odata_d.out_value = rm_q[ri_q] ? '0 : v[24:0];
            default:     odata_d.out_value = '0;
          endcase
          i_d = i_q + 1'b1;
        end
        if (state_d == ST_LOAD) begin
          k_d = '0; rsum_d = '0; rm_d = '0;
        end
      end
      default: ;
    endcase
    if (state_q == ST_EMIT) ri_d = i_q[IdxW-1:0];
    if (state_q == ST_WAIT) ri_d = ri_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD; k_q <= '0; rsum_q <= '0; rm_q <= '0; i_q <= '0;
      rv_q <= 1'b0; ovalid_q <= 1'b0; tol_q <= TolReset; mode_q <= MODE_ZERO;
      m_q <= '0;
    end else begin
      state_q <= state_d; k_q <= k_d; rsum_q <= rsum_d; rm_q <= rm_d;
      i_q <= i_d; rv_q <= rv_d; ovalid_q <= ovalid_d; mode_q <= mode_d;
      m_q <= m_d;
      if (cfg_we_i) tol_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ri_q <= ri_d; acc_q <= acc_d; shift_q <= shift_d; best_q <= best_d;
    bidx_q <= bidx_d; bset_q <= bset_d; ok_q <= ok_d; odata_q <= odata_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o = odata_q;
endmodule

// ----- rtl/core/psp_checker.sv -----
`include "probability_simplex_projection_unit_defines.svh"
module psp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input psp_pkg::psp_out_t out_data_o
);
  import psp_pkg::*;
  `PSP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `PSP_ASSERT_IMP(a_out_range, clk_i, rst_ni, out_valid_o, out_data_o.out_value <= 25'd16777216)
  `PSP_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `PSP_ASSERT_NXT(a_in_quiet, clk_i, rst_ni, in_valid_i && in_ready_o, !out_valid_o)
endmodule

bind probability_simplex_projection_unit psp_checker u_psp_checker (.*);

// ----- tb/tb_probability_simplex_projection_unit.sv -----
module tb_probability_simplex_projection_unit;
  import psp_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [24:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  psp_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  psp_out_t    out_data_o;

  probability_simplex_projection_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("probability_simplex_projection_unit test failed");
    $finish;
  end

  localparam longint QO = 64'sd16777216;
  localparam longint SMX = 64'sd549755813887;
  localparam longint SMN = -64'sd549755813888;

  logic [24:0] tol_q;
  longint      vec_q[$];
  longint      vsum;
  psp_out_t    proj_q[$];
  int          errors = 0;
  bit          idle_en = 1'b1;
  bit          hold_req = 1'b0;

  function automatic longint sat40(longint v);
    if (v > SMX) return SMX;
    if (v < SMN) return SMN;
    return v;
  endfunction

  function automatic bit unit_ok(longint v);
    return v >= 0 && v <= QO;
  endfunction

  task automatic project_vector();
    int     k, maxi, mini, m;
    longint val[64];
    bit     gone[64];
    longint maxv, sabs, shift, s;
    bit     ok;
    psp_out_t o;
    k = vec_q.size();
    maxi = 0;
    sabs = 0;
    for (int i = 0; i < 64; i++) begin
      val[i] = 0;
      gone[i] = 0;
    end
    maxv = vec_q[0];
    for (int i = 0; i < k; i++) begin
      if (vec_q[i] > maxv) begin
        maxv = vec_q[i];
        maxi = i;
      end
      sabs = sat40(sabs + (vec_q[i] < 0 ? -vec_q[i] : vec_q[i]));
    end
    if (maxv > 0 && sabs - maxv < longint'(tol_q)) begin
      val[maxi] = QO;
    end else begin
      shift = (QO - vsum) / k;
      ok = 1;
      for (int i = 0; i < k; i++) begin
        val[i] = vec_q[i] + shift;
        if (!unit_ok(val[i])) ok = 0;
      end
      m = k;
      while (!ok && m > 0) begin
        mini = k;
        for (int i = 0; i < k; i++)
          if (!gone[i] && (mini == k || vec_q[i] < vec_q[mini])) mini = i;
        gone[mini] = 1;
        m--;
        for (int i = 0; i < 64; i++) val[i] = 0;
        if (m == 0) break;
        s = 0;
        for (int i = 0; i < k; i++) if (!gone[i]) s = sat40(s + vec_q[i]);
        shift = (QO - s) / m;
        ok = 1;
        for (int i = 0; i < k; i++) begin
          if (gone[i]) continue;
          val[i] = vec_q[i] + shift;
          if (!unit_ok(val[i])) ok = 0;
        end
      end
      if (!ok) for (int i = 0; i < 64; i++) val[i] = 0;
    end
    for (int i = 0; i < k; i++) begin
      o.out_value = val[i][24:0];
      o.out_last = (i == k - 1);
      proj_q.push_back(o);
    end
    vec_q.delete();
    vsum = 0;
  endtask

  task automatic absorb(psp_in_t b);
    vec_q.push_back(longint'(b.in_value));
    vsum = sat40(vsum + longint'(b.in_value));
    if (b.in_last || vec_q.size() >= 64) project_vector();
  endtask

  task automatic send(psp_in_t b);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    absorb(b);
  endtask

  task automatic send_vec(int k, int kind);
    psp_in_t b;
    for (int i = 0; i < k; i++) begin
      case (kind)
        0: b.in_value = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        1: b.in_value = $urandom;
        default: b.in_value = $urandom_range(0, 32'h0040_0000);
      endcase
      b.in_last = (i == k - 1);
      send(b);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (proj_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_tol(logic [24:0] t);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= t;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tol_q = t;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (proj_q.size() == 0) begin
        $error("unexpected beat value %0h", out_data_o.out_value);
        errors++;
      end else begin
        if (out_data_o.out_value !== proj_q[0].out_value) begin
          $error("out_value exp %0h act %0h", proj_q[0].out_value, out_data_o.out_value);
          errors++;
        end
        if (out_data_o.out_last !== proj_q[0].out_last) begin
          $error("out_last exp %0b act %0b", proj_q[0].out_last, out_data_o.out_last);
          errors++;
        end
        void'(proj_q.pop_front());
      end
    end
  end

  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (20000) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 19);
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  typedef struct {
    logic signed [31:0] v;
    logic               l;
    logic               chk;
    logic [24:0]        ev;
  } row_t;

  row_t rows[] = '{
    '{32'sd16777216, 1'b1, 1'b1, 25'd16777216},
    '{32'sh7fffffff, 1'b1, 1'b1, 25'd16777216},
    '{32'sh80000000, 1'b1, 1'b1, 25'd16777216},
    '{32'sd0, 1'b1, 1'b1, 25'd16777216},
    '{32'sd0, 1'b0, 1'b0, 25'd0},
    '{32'sd0, 1'b1, 1'b0, 25'd0},
    '{32'sd5000000, 1'b0, 1'b0, 25'd0},
    '{32'sd5000000, 1'b1, 1'b0, 25'd0},
    '{32'sh80000000, 1'b0, 1'b0, 25'd0},
    '{32'sh7fffffff, 1'b0, 1'b0, 25'd0},
    '{32'sd3, 1'b1, 1'b0, 25'd0},
    '{-32'sd8000000, 1'b0, 1'b0, 25'd0},
    '{-32'sd8000000, 1'b0, 1'b0, 25'd0},
    '{32'sd30000000, 1'b0, 1'b0, 25'd0},
    '{32'sd100, 1'b1, 1'b0, 25'd0},
    '{32'sd4000000, 1'b0, 1'b0, 25'd0},
    '{32'sd100, 1'b0, 1'b0, 25'd0},
    '{32'sd4000000, 1'b1, 1'b0, 25'd0}
  };

  initial begin
    psp_in_t b;
    int rn;
    int n;
    tol_q = TolReset;
    vsum = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      b.in_value = rows[i].v;
      b.in_last = rows[i].l;
      send(b);
      if (rows[i].chk && proj_q.size() > 0 && proj_q[$].out_value !== rows[i].ev) begin
        $error("table row %0d out_value exp %0h pred %0h", i, rows[i].ev,
               proj_q[$].out_value);
        errors++;
      end
    end
    send_vec(64, 0);
    hold_req = 1'b1;
    send_vec(4, 2);
    send_vec(4, 2);
    set_tol(25'd0);
    send_vec(3, 0);
    b.in_value = 32'sd16777216; b.in_last = 1'b1; send(b);
    set_tol(25'd16777216);
    send_vec(3, 2);
    set_tol(25'h1ffffff);
    send_vec(3, 1);
    set_tol(25'd168);
    rn = 0;
    while (rn < 12) begin
      if (rn > 6) idle_en = 1'b0;
      n = $urandom_range(1, 4);
      case ($urandom_range(0, 3))
        0: send_vec(n, 1);
        1: send_vec(n, 0);
        default: send_vec(n, 2);
      endcase
      rn += n;
    end
    send_vec(2, 0);
    drain();
    if (errors == 0 && proj_q.size() == 0)
      $display("probability_simplex_projection_unit test passed");
    else
      $display("probability_simplex_projection_unit test failed");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/psp_pkg.sv
rtl/core/psp_divider.sv
rtl/core/probability_simplex_projection_unit.sv
rtl/core/psp_checker.sv
tb/tb_probability_simplex_projection_unit.sv
